>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl in this folder
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every rising edge outside reset
`define DAU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define DAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define DAU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/dau_pkg.sv
// types, constants and month-length helper for the date add days unit
// no dependencies
`timescale 1ns / 1ps

package dau_pkg;

  localparam int unsigned YEAR_LIMIT_DEF = 9999;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MON_W     = 4;
  localparam int unsigned IN_YEAR_W = 14;
  localparam int unsigned OFF_W     = 16;
  // internal year holds up to the largest limit
  localparam int unsigned YEAR_W    = 16;
  // offset magnitude, up to 32768
  localparam int unsigned LEFT_W    = 16;
  // shared subtractor, one bit above its widest operand for the borrow
  localparam int unsigned UNIT_W    = 17;
  localparam int unsigned CENT_W    = 2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [IN_YEAR_W-1:0] CENTURY  = IN_YEAR_W'(100);
  localparam logic [IN_YEAR_W-1:0] REM_LAST = IN_YEAR_W'(99);

  localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
  localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
  localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
  localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);
  localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

  localparam logic [DAY_W-1:0] LEN_LONG  = DAY_W'(31);
  localparam logic [DAY_W-1:0] LEN_SHORT = DAY_W'(30);
  localparam logic [DAY_W-1:0] LEN_LEAP  = DAY_W'(29);
  localparam logic [DAY_W-1:0] LEN_FEB   = DAY_W'(28);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_FWD,
    ST_BWD,
    ST_DONE
  } dau_state_e;

  function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MON_W-1:0] mon);
    logic [DAY_W-1:0] len;
    case (mon) inside
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      MON_FEB: len = leap ? LEN_LEAP : LEN_FEB;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/core/date_add_days_unit.sv
// date add days unit: gregorian date plus a signed day offset, walked month by month
// the year is first split by 100, then the walk runs for a non-zero offset; a bad year skips both
// throughput: one item at a time; a new item is taken once the previous one has left the sequencer
// reset: rst_ni asynchronous active low, clears sequencer state and the output valid flag
// depends on dau_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module date_add_days_unit #(
  parameter int unsigned YEAR_LIMIT = dau_pkg::YEAR_LIMIT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // start_day [4:0], start_month [8:5], start_year [22:9], day_offset [38:23], zero pad
  input  logic [dau_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // result_day [4:0], result_month [8:5], result_year [22:9], zero pad
  output logic [dau_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // range_error [0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  localparam logic [dau_pkg::YEAR_W-1:0] YEAR_MAX = dau_pkg::YEAR_W'(YEAR_LIMIT);
  localparam logic [dau_pkg::YEAR_W-1:0] YEAR_MIN = dau_pkg::YEAR_W'(1);

  // input item fields
  logic [dau_pkg::DAY_W-1:0]     in_day;
  logic [dau_pkg::MON_W-1:0]     in_mon;
  logic [dau_pkg::IN_YEAR_W-1:0] in_year;
  logic [dau_pkg::OFF_W-1:0]     in_off;

  assign in_day  = s_axis_tdata[4:0];
  assign in_mon  = s_axis_tdata[8:5];
  assign in_year = s_axis_tdata[22:9];
  assign in_off  = s_axis_tdata[38:23];

  // sequencer state
  dau_pkg::dau_state_e state_q, state_d;
  logic [dau_pkg::DAY_W-1:0]     day_q, day_d;
  logic [dau_pkg::MON_W-1:0]     mon_q, mon_d;
  logic [dau_pkg::YEAR_W-1:0]    year_q, year_d;
  // year mod 100 and year div 100 mod 4, kept in step with year_q
  logic [dau_pkg::IN_YEAR_W-1:0] rem_q, rem_d;
  logic [dau_pkg::CENT_W-1:0]    cent_q, cent_d;
  // days still to walk, as a magnitude
  logic [dau_pkg::LEFT_W-1:0]    left_q, left_d;
  logic                          fwd_q, fwd_d;
  logic                          err_q, err_d;

  // echo copy of the input date
  logic [dau_pkg::DAY_W-1:0]     echo_day_q;
  logic [dau_pkg::MON_W-1:0]     echo_mon_q;
  logic [dau_pkg::IN_YEAR_W-1:0] echo_year_q;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [dau_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                           out_err_q;
  logic                           out_load;

  logic in_fire;
  assign s_axis_tready = (state_q == dau_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // leap year from the running remainders
  logic                      leap;
  logic [dau_pkg::DAY_W-1:0] cur_len;
  logic [dau_pkg::DAY_W-1:0] prev_len;
  logic [dau_pkg::MON_W-1:0] mon_prev;

  assign leap     = (rem_q[1:0] == 2'd0) &&
                    ((rem_q != '0) || (cent_q == '0));
  assign cur_len  = dau_pkg::month_len(leap, mon_q);
  assign mon_prev = mon_q - dau_pkg::MON_W'(1);
  assign prev_len = dau_pkg::month_len(leap, mon_prev);

  // shared compare and subtract unit: a - b, ge when no borrow
  logic [dau_pkg::UNIT_W-1:0] unit_a, unit_b, unit_diff;
  logic                       unit_ge;

  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_q)
      dau_pkg::ST_DIV: begin
        unit_a = dau_pkg::UNIT_W'(rem_q);
        unit_b = dau_pkg::UNIT_W'(dau_pkg::CENTURY);
      end
      dau_pkg::ST_FWD: begin
        // days to the first of next month
        unit_a = dau_pkg::UNIT_W'(left_q);
        unit_b = dau_pkg::UNIT_W'(cur_len) - dau_pkg::UNIT_W'(day_q) + dau_pkg::UNIT_W'(1);
      end
      dau_pkg::ST_BWD: begin
        // days back to the last of previous month
        unit_a = dau_pkg::UNIT_W'(left_q);
        unit_b = dau_pkg::UNIT_W'(day_q);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
    unit_diff = unit_a - unit_b;
    unit_ge   = !unit_diff[dau_pkg::UNIT_W-1];
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    day_d    = day_q;
    mon_d    = mon_q;
    year_d   = year_q;
    rem_d    = rem_q;
    cent_d   = cent_q;
    left_d   = left_q;
    fwd_d    = fwd_q;
    err_d    = err_q;
    out_load = 1'b0;

    unique case (state_q)
      dau_pkg::ST_IDLE: begin
        if (in_fire) begin
          day_d  = in_day;
          mon_d  = in_mon;
          year_d = dau_pkg::YEAR_W'(in_year);
          rem_d  = in_year;
          cent_d = '0;
          fwd_d  = !in_off[dau_pkg::OFF_W-1];
          // two's complement magnitude; the most negative offset gives 32768
          left_d = in_off[dau_pkg::OFF_W-1] ? (~in_off + dau_pkg::OFF_W'(1)) : in_off;
          err_d  = 1'b0;
          if ((in_year == '0) || (dau_pkg::YEAR_W'(in_year) > YEAR_MAX)) begin
            err_d   = 1'b1;
            state_d = dau_pkg::ST_DONE;
          end else begin
            state_d = dau_pkg::ST_DIV;
          end
        end
      end

      dau_pkg::ST_DIV: begin
        // split year into year div 100 and year mod 100
        if (unit_ge) begin
          rem_d  = unit_diff[dau_pkg::IN_YEAR_W-1:0];
          cent_d = cent_q + dau_pkg::CENT_W'(1);
        end else begin
          state_d = dau_pkg::ST_CHECK;
        end
      end

      dau_pkg::ST_CHECK: begin
        if ((mon_q == '0) || (mon_q > dau_pkg::MON_DEC) ||
            (day_q == '0) || (day_q > cur_len)) begin
          err_d   = 1'b1;
          state_d = dau_pkg::ST_DONE;
        end else if (left_q == '0) begin
          state_d = dau_pkg::ST_DONE;
        end else if (fwd_q) begin
          state_d = dau_pkg::ST_FWD;
        end else begin
          state_d = dau_pkg::ST_BWD;
        end
      end

      dau_pkg::ST_FWD: begin
        if (unit_ge) begin
          left_d = unit_diff[dau_pkg::LEFT_W-1:0];
          day_d  = dau_pkg::DAY_W'(1);
          if (mon_q == dau_pkg::MON_DEC) begin
            if (year_q == YEAR_MAX) begin
              // walk leaves the year range, nothing further can bring it back
              err_d   = 1'b1;
              state_d = dau_pkg::ST_DONE;
            end else begin
              mon_d  = dau_pkg::MON_JAN;
              year_d = year_q + dau_pkg::YEAR_W'(1);
              if (rem_q == dau_pkg::REM_LAST) begin
                rem_d  = '0;
                cent_d = cent_q + dau_pkg::CENT_W'(1);
              end else begin
                rem_d = rem_q + dau_pkg::IN_YEAR_W'(1);
              end
            end
          end else begin
            mon_d = mon_q + dau_pkg::MON_W'(1);
          end
        end else begin
          // remainder lands inside this month
          day_d   = day_q + left_q[dau_pkg::DAY_W-1:0];
          state_d = dau_pkg::ST_DONE;
        end
      end

      dau_pkg::ST_BWD: begin
        if (unit_ge) begin
          left_d = unit_diff[dau_pkg::LEFT_W-1:0];
          if (mon_q == dau_pkg::MON_JAN) begin
            if (year_q == YEAR_MIN) begin
              err_d   = 1'b1;
              state_d = dau_pkg::ST_DONE;
            end else begin
              mon_d  = dau_pkg::MON_DEC;
              day_d  = dau_pkg::LEN_LONG;
              year_d = year_q - dau_pkg::YEAR_W'(1);
              if (rem_q == '0) begin
                rem_d  = dau_pkg::REM_LAST;
                cent_d = cent_q - dau_pkg::CENT_W'(1);
              end else begin
                rem_d = rem_q - dau_pkg::IN_YEAR_W'(1);
              end
            end
          end else begin
            // same year, so the current leap flag holds for february
            mon_d = mon_prev;
            day_d = prev_len;
          end
        end else begin
          day_d   = day_q - left_q[dau_pkg::DAY_W-1:0];
          state_d = dau_pkg::ST_DONE;
        end
      end

      dau_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = dau_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dau_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dau_pkg::ST_IDLE;
      fwd_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fwd_q   <= fwd_d;
      err_q   <= err_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    day_q  <= day_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    rem_q  <= rem_d;
    cent_q <= cent_d;
    left_q <= left_d;
    if (in_fire) begin
      echo_day_q  <= in_day;
      echo_mon_q  <= in_mon;
      echo_year_q <= in_year;
    end
  end

  // output register, so a finished item can wait while the next is taken
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_err_q <= err_q;
      if (err_q) begin
        out_data_q <= {1'b0, echo_year_q, echo_mon_q, echo_day_q};
      end else begin
        out_data_q <= {1'b0, year_q[dau_pkg::IN_YEAR_W-1:0], mon_q, day_q};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  // short names for the checks below
  logic walk_st;
  logic split_done;
  logic done_st;
  logic res_good;
  logic res_date_ok;
  logic walk_day_ok;
  logic rem_ok;

  assign walk_st     = (state_q == dau_pkg::ST_FWD) || (state_q == dau_pkg::ST_BWD);
  assign split_done  = walk_st || (state_q == dau_pkg::ST_CHECK);
  assign done_st     = (state_q == dau_pkg::ST_DONE);
  assign res_good    = m_axis_tvalid && !m_axis_tuser;
  assign res_date_ok = (m_axis_tdata[8:5] != '0) && (m_axis_tdata[8:5] <= dau_pkg::MON_DEC) &&
                       (m_axis_tdata[4:0] != '0);
  assign walk_day_ok = (day_q != '0) && (day_q <= cur_len);
  assign rem_ok      = (rem_q < dau_pkg::CENTURY);

  // a taken item keeps the sequencer busy for at least the next cycle
  `DAU_ASSERT(a_busy_after_take, clk_i, rst_ni, in_fire |=> !s_axis_tready, "ready right after take")

  // a good result always carries a month from 1 to 12 and a non-zero day
  `DAU_ASSERT(a_result_date, clk_i, rst_ni, res_good |-> res_date_ok, "bad result date")

  // the walk only runs from a day inside its month
  `DAU_ASSERT(a_walk_day, clk_i, rst_ni, walk_st |-> walk_day_ok, "walk day outside month")

  // year mod 100 stays reduced once the split is finished
  `DAU_ASSERT(a_rem_reduced, clk_i, rst_ni, split_done |-> rem_ok, "year remainder not reduced")

  // output valid only comes up from a load by the sequencer
  `DAU_ASSERT(a_valid_source, clk_i, rst_ni, $rose(out_valid_q) |-> $past(done_st), "valid without load")

endmodule

>>> tb/sv/testbench.sv
// self-checking bench for date_add_days_unit: directed and random dates with signed offsets
// depends on dau_pkg and the date_add_days_unit rtl
`timescale 1ns / 1ps

// one expected result, fields as they leave the block
typedef struct packed {
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic        range_error;
} shifted_date_t;

class date_scoreboard;
  shifted_date_t expected_dates[$];
  int unsigned   mismatch_count;
  int unsigned   results_seen;

  static function bit is_leap_year(int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  static function int days_in_month(int y, int m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // walk month by month, echoing the start date when it is bad or the walk leaves range
  function shifted_date_t shift_date(logic [4:0] d_in, logic [3:0] m_in, logic [13:0] y_in,
                                     logic signed [15:0] off_in);
    int            d;
    int            m;
    int            y;
    int            off;
    int            left;
    bit            err;
    shifted_date_t res;
    d   = d_in;
    m   = m_in;
    y   = y_in;
    off = off_in;
    err = (m < 1 || m > 12 || y < 1 || y > int'(dau_pkg::YEAR_LIMIT_DEF) ||
           d < 1 || d > days_in_month(y, m));
    if (!err && off > 0) begin
      left = off;
      while (left > days_in_month(y, m) - d) begin
        left -= days_in_month(y, m) - d + 1;
        d = 1;
        if (m == 12) begin
          m = 1;
          y++;
        end else begin
          m++;
        end
      end
      d += left;
    end else if (!err && off < 0) begin
      left = -off;
      while (left >= d) begin
        left -= d;
        if (m == 1) begin
          m = 12;
          y--;
        end else begin
          m--;
        end
        d = days_in_month(y, m);
      end
      d -= left;
    end
    if (!err && (y < 1 || y > int'(dau_pkg::YEAR_LIMIT_DEF))) err = 1'b1;
    if (err) begin
      res = '{day: d_in, month: m_in, year: y_in, range_error: 1'b1};
    end else begin
      res = '{day: d[4:0], month: m[3:0], year: y[13:0], range_error: 1'b0};
    end
    return res;
  endfunction

  function void note_input(logic [dau_pkg::IN_DATA_W-1:0] data);
    expected_dates.push_back(shift_date(data[4:0], data[8:5], data[22:9], data[38:23]));
  endfunction

  function void check_result(logic [dau_pkg::OUT_DATA_W-1:0] data, logic err);
    shifted_date_t want;
    shifted_date_t got;
    got = '{day: data[4:0], month: data[8:5], year: data[22:9], range_error: err};
    results_seen++;
    if (expected_dates.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: unexpected %0d/%0d/%0d err %0b", results_seen,
                 got.day, got.month, got.year, got.range_error);
      return;
    end
    want = expected_dates.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: expected %0d/%0d/%0d err %0b, got %0d/%0d/%0d err %0b",
                 results_seen, want.day, want.month, want.year, want.range_error,
                 got.day, got.month, got.year, got.range_error);
    end
  endfunction

  function int pending();
    return expected_dates.size();
  endfunction
endclass

module testbench;

  localparam int RANDOM_ITEMS = 500;
  // worst item: year split plus the month walk for the largest offset
  localparam int DRAIN_CYCLES = 1300;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic [dau_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [dau_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;

  // no idling on either side while set
  bit calm_stretch;

  date_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  date_add_days_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // monitors read pre-edge values, so the bench's own nonblocking updates never race them
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver stalls on about 8 percent of cycles, none during the calm stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm_stretch || ($urandom_range(99) >= 8);
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                           input logic [15:0] off);
    if (!calm_stretch && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tdata  <= {1'b0, off, y, m, d};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // well-formed date, years often near either end, offsets small or across the whole field
  task automatic send_random_valid();
    int          y;
    int          m;
    int          d;
    logic [15:0] off;
    case ($urandom_range(9))
      0:       y = $urandom_range(1, 120);
      1:       y = $urandom_range(dau_pkg::YEAR_LIMIT_DEF - 120, dau_pkg::YEAR_LIMIT_DEF);
      default: y = $urandom_range(1, dau_pkg::YEAR_LIMIT_DEF);
    endcase
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.days_in_month(y, m));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: off = 16'($signed($urandom_range(0, 800)) - 400);
      5:             off = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
      default:       off = 16'($urandom_range(0, 65535));
    endcase
    send_date(5'(d), 4'(m), 14'(y), off);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    calm_stretch  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, leap rules, wraps and every kind of bad input
    send_date(5'd31, 4'd12, 14'd9999, 16'd1);       // past the last year
    send_date(5'd1,  4'd1,  14'd1,    16'hffff);    // before the first year
    send_date(5'd28, 4'd2,  14'd2000, 16'd1);       // leap by four hundred
    send_date(5'd28, 4'd2,  14'd1900, 16'd1);       // century, not leap
    send_date(5'd29, 4'd2,  14'd1900, 16'd0);       // feb 29 in a non-leap year
    send_date(5'd29, 4'd2,  14'd2000, 16'd365);
    send_date(5'd15, 4'd7,  14'd2024, 16'd0);       // zero offset
    send_date(5'd1,  4'd1,  14'd1,    16'h7fff);    // largest step forward
    send_date(5'd31, 4'd12, 14'd9999, 16'h8000);    // largest step back
    send_date(5'd10, 4'd0,  14'd2024, 16'd5);       // month zero
    send_date(5'd10, 4'd13, 14'd2024, 16'd5);
    send_date(5'd31, 4'd15, 14'd2024, 16'd5);
    send_date(5'd0,  4'd6,  14'd2024, 16'd5);       // day zero
    send_date(5'd31, 4'd4,  14'd2024, 16'd5);       // day past end of a short month
    send_date(5'd1,  4'd1,  14'd0,    16'd5);       // year zero
    send_date(5'd1,  4'd1,  14'h3fff, 16'd5);       // year with every bit set
    send_date(5'd1,  4'd1,  14'd10000, 16'd5);
    send_date(5'd31, 4'd12, 14'd2023, 16'd1);       // december into january
    send_date(5'd1,  4'd1,  14'd2024, 16'hffff);    // january back to december
    send_date(5'd15, 4'd6,  14'd2024, 16'h8000);
    send_date(5'd1,  4'd3,  14'd2024, 16'hffff);    // back into a leap february
    send_date(5'd1,  4'd3,  14'd2100, 16'hffff);
    send_date(5'd31, 4'd12, 14'd9999, 16'd0);

    // random: mostly well-formed dates, some raw noise in every field
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_stretch = (n >= 150 && n < 250);
      if ($urandom_range(99) < 85) begin
        send_random_valid();
      end else begin
        send_date(5'($urandom), 4'($urandom), 14'($urandom), 16'($urandom));
      end
    end
    calm_stretch = 1'b0;
    s_axis_tvalid <= 1'b0;

    // let the monitor note the last item before looking at the queue
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // generous cap: several times the slowest legal run
  initial begin
    #30ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
